### hw/rtl/bphu_pkg.sv
// Shared constants, types and state codes of the bin packing heuristics unit.
package bphu_pkg;

	localparam int MAX_ITEMS = 256;
	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [15:0] CAP_RESET = 16'd100;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_INS     = 8'b0000_0010,
		S_INS_END = 8'b0000_0100,
		S_PITEM   = 8'b0000_1000,
		S_PW      = 8'b0001_0000,
		S_PSCAN   = 8'b0010_0000,
		S_PLACE   = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		M_FF  = 2'd0,
		M_BF  = 2'd1,
		M_FFD = 2'd2
	} mode_t;

	typedef struct packed {
		logic [8:0] first_fit_bins;
		logic [8:0] decreasing_bins;
		logic [8:0] best_fit_bins;
		logic       overflowed;
	} bphu_result_t;

endpackage

### hw/rtl/bphu_if.sv
// Valid/ready channel interfaces for input items and result items.
interface bphu_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] weight;
	logic        last_item;
	modport source (output valid, output weight, output last_item, input ready);
	modport sink (input valid, input weight, input last_item, output ready);
endinterface

interface bphu_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] first_fit_bins;
	logic [8:0] decreasing_bins;
	logic [8:0] best_fit_bins;
	logic       overflowed;
	modport source (output valid, output first_fit_bins, output decreasing_bins,
		output best_fit_bins, output overflowed, input ready);
	modport sink (input valid, input first_fit_bins, input decreasing_bins,
		input best_fit_bins, input overflowed, output ready);
endinterface

### hw/rtl/bphu_ram.sv
// Generic single write port, single registered read port RAM.
module bphu_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/bphu_seq.sv
// Sequencer that stores, sorts and packs the item set with one shared fit unit.
module bphu_seq import bphu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [15:0]  capacity,
	bphu_in_if.sink      items,
	output logic         res_valid,
	input  logic         res_take,
	output bphu_result_t res
);
	state_t          state_q;
	mode_t           mode_q;
	logic [CW-1:0]   cnt_q, i_q, used_q, ff_q, bf_q, ffd_q;
	logic            ovf_q, last_q, found_q;
	logic [15:0]     ins_v_q, w_q, best_q;
	logic [IW-1:0]   ins_j_q, j_q, pick_q;

	logic            accept, room, adv, last_i, fit, scan_more, better;
	logic            st_we, so_we, ld_we;
	logic [IW-1:0]   so_waddr, so_raddr, ld_waddr, ld_raddr;
	logic [15:0]     so_wdata, ld_wdata, st_rd, so_rd, ld_rd, w_rd;
	logic [16:0]     sum;
	logic [CW-1:0]   used_nx;

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid & items.ready;
	assign room        = (cnt_q != CW'(MAX_ITEMS));
	assign st_we       = accept & room;
	assign w_rd        = (mode_q == M_FFD) ? so_rd : st_rd;
	assign sum         = {1'b0, ld_rd} + {1'b0, w_q};
	assign fit         = (sum <= {1'b0, capacity});
	assign better      = (!found_q) || (ld_rd > best_q);
	assign scan_more   = (CW'(j_q) + 1'b1) < used_q;
	assign last_i      = (i_q + 1'b1) == cnt_q;
	assign used_nx     = (state_q == S_PLACE && !(mode_q == M_BF && found_q) && w_q != '0)
		? used_q + 1'b1 : used_q;

	always_comb begin
		so_we    = 1'b0;
		so_waddr = ins_j_q;
		so_wdata = ins_v_q;
		so_raddr = i_q[IW-1:0];
		ld_we    = 1'b0;
		ld_waddr = j_q;
		ld_wdata = sum[15:0];
		ld_raddr = j_q;
		adv      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (st_we) begin
					if (cnt_q == '0) begin
						so_we    = 1'b1;
						so_waddr = '0;
						so_wdata = items.weight;
					end else begin
						so_raddr = cnt_q[IW-1:0] - 1'b1;
					end
				end
			end
			S_INS: begin
				so_we = 1'b1;
				if (so_rd < ins_v_q) begin
					so_wdata = so_rd;
					so_raddr = ins_j_q - IW'(2);
				end
			end
			S_INS_END: so_we = 1'b1;
			S_PW: begin
				ld_raddr = '0;
				adv      = (w_rd > capacity);
			end
			S_PSCAN: begin
				ld_raddr = j_q + 1'b1;
				if (mode_q != M_BF && fit) begin
					ld_we = 1'b1;
					adv   = 1'b1;
				end
			end
			S_PLACE: begin
				ld_we = 1'b1;
				adv   = 1'b1;
				if (mode_q == M_BF && found_q) begin
					ld_waddr = pick_q;
					ld_wdata = best_q + w_q;
				end else begin
					ld_waddr = used_q[IW-1:0];
					ld_wdata = w_q;
				end
			end
			default: ;
		endcase
	end

	bphu_ram #(.DEPTH(MAX_ITEMS), .WIDTH(16)) u_store (
		.clk(clk), .we(st_we), .waddr(cnt_q[IW-1:0]), .wdata(items.weight),
		.raddr(i_q[IW-1:0]), .rdata(st_rd)
	);

	bphu_ram #(.DEPTH(MAX_ITEMS), .WIDTH(16)) u_sorted (
		.clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(so_rd)
	);

	bphu_ram #(.DEPTH(MAX_ITEMS), .WIDTH(16)) u_loads (
		.clk(clk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
		.raddr(ld_raddr), .rdata(ld_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= M_FF;
			cnt_q   <= '0;
			i_q     <= '0;
			used_q  <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q   <= cnt_q + 1'b1;
							ins_v_q <= items.weight;
							ins_j_q <= cnt_q[IW-1:0];
							last_q  <= items.last_item;
							if (cnt_q != '0) begin
								state_q <= S_INS;
							end else if (items.last_item) begin
								state_q <= S_PITEM;
							end
						end else begin
							ovf_q <= 1'b1;
							if (items.last_item) begin
								state_q <= S_PITEM;
							end
						end
						i_q    <= '0;
						used_q <= '0;
						mode_q <= M_FF;
					end
				end
				S_INS: begin
					if (so_rd < ins_v_q) begin
						ins_j_q <= ins_j_q - 1'b1;
						if (ins_j_q == IW'(1)) begin
							state_q <= S_INS_END;
						end
					end else begin
						state_q <= last_q ? S_PITEM : S_IDLE;
					end
				end
				S_INS_END: state_q <= last_q ? S_PITEM : S_IDLE;
				S_PITEM: state_q <= S_PW;
				S_PW: begin
					if (!adv) begin
						w_q     <= w_rd;
						j_q     <= '0;
						found_q <= 1'b0;
						state_q <= (used_q == '0) ? S_PLACE : S_PSCAN;
					end
				end
				S_PSCAN: begin
					if (!adv) begin
						if (mode_q == M_BF && fit && better) begin
							found_q <= 1'b1;
							best_q  <= ld_rd;
							pick_q  <= j_q;
						end
						if (scan_more) begin
							j_q <= j_q + 1'b1;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_PLACE: ;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (adv) begin
				if (last_i) begin
					i_q    <= '0;
					used_q <= '0;
					case (mode_q)
						M_FF: begin
							ff_q    <= used_nx;
							mode_q  <= M_BF;
							state_q <= S_PITEM;
						end
						M_BF: begin
							bf_q    <= used_nx;
							mode_q  <= M_FFD;
							state_q <= S_PITEM;
						end
						default: begin
							ffd_q   <= used_nx;
							state_q <= S_DONE;
						end
					endcase
				end else begin
					i_q     <= i_q + 1'b1;
					used_q  <= used_nx;
					state_q <= S_PITEM;
				end
			end
		end
	end

	assign res_valid           = (state_q == S_DONE);
	assign res.first_fit_bins  = 9'(ff_q);
	assign res.decreasing_bins = 9'(ffd_q);
	assign res.best_fit_bins   = 9'(bf_q);
	assign res.overflowed      = ovf_q;
endmodule

### hw/rtl/bin_packing_heuristics_unit.sv
// Top level of the bin packing heuristics unit with capacity register and result register.
//
//   channel   dir  payload                                            handshake
//   items     in   weight[15:0], last_item                            valid/ready
//   results   out  first_fit_bins, decreasing_bins, best_fit_bins,    valid/ready
//                  overflowed
//   cfg       in   cfg_wdata[15:0] (bin capacity)                     cfg_we
//
// The first item of a set is stored directly and an ignored item is dropped; any other item
// is stored and moved down one place at a time into descending order. The last item then
// starts three packing passes; each item is fetched, its weight read, the open bins in the
// shared load RAM scanned and the item placed. Input ready is low for all of this.
// Reset clears the counters and sets the capacity to 100; the stores need no clearing.
// A finished result waits in the output register while the next set loads.
module bin_packing_heuristics_unit import bphu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	bphu_in_if.sink     items,
	bphu_out_if.source  results
);
	logic [15:0]  capacity_q;
	logic         res_valid, res_take, out_valid_q;
	bphu_result_t res, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	bphu_seq u_seq (
		.clk(clk), .arst_n(arst_n), .capacity(capacity_q), .items(items),
		.res_valid(res_valid), .res_take(res_take), .res(res)
	);

	assign res_take = res_valid & (!out_valid_q | results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.first_fit_bins  = out_q.first_fit_bins;
	assign results.decreasing_bins = out_q.decreasing_bins;
	assign results.best_fit_bins   = out_q.best_fit_bins;
	assign results.overflowed      = out_q.overflowed;
endmodule
